### hdl/http_chunked_body_decoder_macros.svh
// Assertion macros used by the checker file of the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HCBD_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("hcbd check failed");

// Next-cycle implication, disabled during reset.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("hcbd check failed");

`endif

### hdl/hcbd_pkg.sv
// Shared constants, result type and hex decode function of the chunked body decoder.
package hcbd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int LEN_BITS   = 32;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] LO_A_BIAS  = 8'h57;
    localparam logic [7:0] UP_A_BIAS  = 8'h37;

    typedef struct packed {
        logic [LEN_BITS-1:0] decoded_length;
        logic                status;
        logic                end_of_body;
        logic                data_valid;
        logic [7:0]          data_out;
    } hcbd_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hcbd_hex_t;

    function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
        hcbd_hex_t h;
        logic [7:0] diff;
        h.valid = 1'b0;
        h.value = 4'd0;
        diff    = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            h.valid = 1'b1;
            h.value = c[3:0];
        end
        else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
        begin
            diff    = c - LO_A_BIAS;
            h.valid = 1'b1;
            h.value = diff[3:0];
        end
        else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
        begin
            diff    = c - UP_A_BIAS;
            h.valid = 1'b1;
            h.value = diff[3:0];
        end
        return h;
    endfunction

endpackage

### hdl/http_chunked_body_decoder.sv
// Top level of the chunked HTTP body decoder: input register, parser and output skid stage.
//
// Usage:
//   s_axis carries the chunked body one byte per transaction; s_axis_tlast marks the
//   final byte of a body. m_axis carries one result per payload byte and one on the
//   final byte: tdata holds the byte (zero when not payload) and the running payload
//   count, tuser flags payload and malformed status, tlast marks end of body.
//   Bytes of the size lines, extensions and CRLFs produce no result.
//   A result passes from the input register through the parser to the output register,
//   then appears on m_axis. Throughput: one byte per cycle while m_axis does not stall;
//   each byte takes one pass through the parser between the two registers.
//   Reset clears the parser to the start of a body and empties both stages.
//   When m_axis stalls, the skid stage holds one more result, then s_axis_tready
//   drops until the output drains; no transaction is lost or repeated.
//   After the end-of-body result the next byte begins a new body. Payload passed
//   before a malformed status must be discarded downstream.
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] data_out, [39:8] decoded_length
    output logic [1:0]  m_axis_tuser,   // [0] data_valid, [1] status
    output logic        m_axis_tlast    // end_of_body
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    logic         s_accept;
    logic         step;
    logic         skid_ready;
    logic         res_valid;
    hcbd_result_t res;
    hcbd_result_t out_res;

    assign step          = in_valid_reg & skid_ready;
    assign s_axis_tready = ~in_valid_reg | skid_ready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign in_valid_next = s_accept | (in_valid_reg & ~step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    hcbd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_data_reg),
        .last_in   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hcbd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (skid_ready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.decoded_length, out_res.data_out};
    assign m_axis_tuser = {out_res.status, out_res.data_valid};
    assign m_axis_tlast = out_res.end_of_body;

endmodule

### hdl/hcbd_parser.sv
// Chunk framing state machine, size accumulator and payload counter.
module hcbd_parser
    import hcbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   byte_in,
    input  logic         last_in,
    output logic         res_valid,
    output hcbd_result_t res
);

    localparam logic [3:0] MODE_SIZE_START  = 4'd0;
    localparam logic [3:0] MODE_SIZE_DIGITS = 4'd1;
    localparam logic [3:0] MODE_EXT         = 4'd2;
    localparam logic [3:0] MODE_SIZE_LF     = 4'd3;
    localparam logic [3:0] MODE_DATA        = 4'd4;
    localparam logic [3:0] MODE_AFTER_DATA  = 4'd5;
    localparam logic [3:0] MODE_AFTER_CR    = 4'd6;
    localparam logic [3:0] MODE_DONE        = 4'd7;
    localparam logic [3:0] MODE_ERROR       = 4'd8;

    logic [3:0]            mode_reg;
    logic [3:0]            mode_next;
    logic [COUNT_BITS-1:0] chunk_reg;
    logic [COUNT_BITS-1:0] chunk_next;
    logic [LEN_BITS-1:0]   pay_reg;
    logic [LEN_BITS-1:0]   pay_next;
    logic [3:0]            mode_cur;
    logic [3:0]            mode_upd;
    logic [COUNT_BITS-1:0] chunk_upd;
    logic [LEN_BITS-1:0]   pay_upd;
    logic                  emit;
    logic                  body_ok;
    logic                  size_full;
    hcbd_hex_t             hex;

    assign hex       = hex_decode(byte_in);
    assign size_full = |chunk_reg[COUNT_BITS-1:COUNT_BITS-4];

    always_comb
    begin
        mode_cur = mode_reg;
        if (mode_reg == MODE_AFTER_DATA && byte_in != CHAR_CR)
        begin
            mode_cur = MODE_SIZE_START;
        end
        mode_upd  = mode_cur;
        chunk_upd = chunk_reg;
        pay_upd   = pay_reg;
        emit      = 1'b0;
        unique case (mode_cur)
            MODE_SIZE_START:
            begin
                chunk_upd = {{(COUNT_BITS-4){1'b0}}, hex.value};
                mode_upd  = hex.valid ? MODE_SIZE_DIGITS : MODE_ERROR;
            end
            MODE_SIZE_DIGITS:
            begin
                priority if (byte_in == CHAR_CR)
                    mode_upd = MODE_SIZE_LF;
                else if (byte_in == CHAR_SEMI)
                    mode_upd = MODE_EXT;
                else if (!hex.valid || size_full)
                    mode_upd = MODE_ERROR;
                else
                    chunk_upd = {chunk_reg[COUNT_BITS-5:0], hex.value};
            end
            MODE_EXT:
            begin
                if (byte_in == CHAR_CR)
                    mode_upd = MODE_SIZE_LF;
            end
            MODE_SIZE_LF:
            begin
                priority if (byte_in != CHAR_LF)
                    mode_upd = MODE_ERROR;
                else if (chunk_reg == '0)
                    mode_upd = MODE_DONE;
                else
                    mode_upd = MODE_DATA;
            end
            MODE_DATA:
            begin
                emit      = 1'b1;
                pay_upd   = pay_reg + LEN_BITS'(1);
                chunk_upd = chunk_reg - COUNT_BITS'(1);
                if (chunk_reg == COUNT_BITS'(1))
                    mode_upd = MODE_AFTER_DATA;
            end
            MODE_AFTER_DATA:
            begin
                mode_upd = MODE_AFTER_CR;
            end
            MODE_AFTER_CR:
            begin
                mode_upd = (byte_in == CHAR_LF) ? MODE_SIZE_START : MODE_ERROR;
            end
            MODE_DONE:
            begin
                mode_upd = MODE_DONE;
            end
            default:
            begin
                mode_upd = MODE_ERROR;
            end
        endcase

        body_ok = (mode_upd == MODE_DONE) || (mode_upd == MODE_SIZE_START) ||
                  (mode_upd == MODE_AFTER_DATA);

        res.data_out       = emit ? byte_in : 8'd0;
        res.data_valid     = emit;
        res.end_of_body    = last_in;
        res.status         = last_in & ~body_ok;
        res.decoded_length = pay_upd;
        res_valid          = step & (emit | last_in);

        mode_next  = mode_reg;
        chunk_next = chunk_reg;
        pay_next   = pay_reg;
        if (step)
        begin
            if (last_in)
            begin
                mode_next  = MODE_SIZE_START;
                chunk_next = '0;
                pay_next   = '0;
            end
            else
            begin
                mode_next  = mode_upd;
                chunk_next = chunk_upd;
                pay_next   = pay_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SIZE_START;
            chunk_reg <= '0;
            pay_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            chunk_reg <= chunk_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

### hdl/hcbd_skid.sv
// Output register with a skid stage between the parser and the result channel.
module hcbd_skid
    import hcbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  hcbd_result_t in_res,
    output logic         in_ready,
    output logic         out_valid,
    output hcbd_result_t out_res,
    input  logic         out_ready
);

    logic         main_valid_reg;
    logic         main_valid_next;
    hcbd_result_t main_res_reg;
    hcbd_result_t main_res_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    hcbd_result_t skid_res_reg;
    hcbd_result_t skid_res_next;
    logic         take;
    logic         pop;

    assign in_ready  = ~skid_valid_reg;
    assign take      = in_valid & ~skid_valid_reg;
    assign pop       = main_valid_reg & out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_res_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_res_next   = main_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!main_valid_reg || pop)
        begin
            main_valid_next = skid_valid_reg | take;
            main_res_next   = skid_valid_reg ? skid_res_reg : in_res;
            skid_valid_next = 1'b0;
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_res_reg <= main_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

### hdl/hcbd_checker.sv
// Port-level checks for the chunked body decoder and their bind to the top level.
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `HCBD_ASSERT_IMPLIES(a_zero_when_not_payload, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[7:0] == 8'd0)
    `HCBD_ASSERT_IMPLIES(a_status_only_at_end, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !m_axis_tuser[1])
    `HCBD_ASSERT_IMPLIES(a_mid_body_is_payload, clk, rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0])
    `HCBD_ASSERT_NEXT(a_out_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
